// File: hdl/oaht_pkg.sv
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared widths, request codes, result codes and slot state codes for the
// open-addressing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

    // Field widths
    localparam int KEY_W    = 31;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 5;

    // Saturation limit of the removal count
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] res_status_t;
    typedef logic [1:0]          slot_state_t;

    // Request codes
    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_SEARCH = 2'd1;
    localparam req_t REQ_DELETE = 2'd2;

    // Result codes
    localparam res_status_t RES_DONE      = 2'd0;
    localparam res_status_t RES_NOT_FOUND = 2'd1;
    localparam res_status_t RES_FULL      = 2'd2;

    // Slot states
    localparam slot_state_t ST_EMPTY    = 2'd0;
    localparam slot_state_t ST_OCCUPIED = 2'd1;
    localparam slot_state_t ST_DELETED  = 2'd2;

endpackage

`default_nettype wire

// File: hdl/open_address_hash_table.sv
// ----------------------------------------------------------------------------
// open_address_hash_table
// Open-addressing hash table with linear probing over SLOTS slots. Handles
// insert, search and delete requests, one result item per request item.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory to the empty state, one slot a
// cycle, with s_tready low. A request is then accepted (the key is multiplied
// by a scaled reciprocal of SLOTS on the way in), the key modulo SLOTS is
// finished (quotient times SLOTS taken off the key), the slots are probed one
// per cycle through the registered single read port of the slot memory, a run
// that visited every slot is closed once its last read has been checked, and
// the result is handed to the output register. An unused request type skips
// the key reduction and probing and goes straight to the response state. The
// output register lets a new request be accepted while the previous result
// still waits; a request finished while that result is still stalled holds in
// the response state until the output register frees up.
`default_nettype none

module open_address_hash_table #(
    parameter int SLOTS = 31
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: key[30:0]
    input  wire logic [31:0] s_tdata,
    // s_tuser: req_type[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // m_tdata: slot_index[4:0], removed_count[9:5]
    output logic [15:0]      m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]       m_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int KW = oaht_pkg::KEY_W;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = KW + 2;

    // Reciprocal of SLOTS scaled by 2^SH; the quotient is exact for every key
    localparam int SH  = KW + $clog2(SLOTS);
    localparam int RCW = 32;
    localparam int PW  = KW + RCW;
    localparam logic [RCW-1:0] RECIP =
        RCW'(((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] addr_reg, addr_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          chk_valid_reg, chk_valid_next;
    logic          m_valid_reg, m_valid_next;

    // Payload state
    oaht_pkg::req_t        req_reg, req_next;
    logic [KW-1:0]         key_reg, key_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [SW-1:0]         chk_addr_reg;
    logic [oaht_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [SW-1:0]         first_reg, first_next;
    oaht_pkg::res_status_t res_status_reg, res_status_next;
    logic [oaht_pkg::IDX_W-1:0] res_slot_reg, res_slot_next;
    logic [oaht_pkg::CNT_W-1:0] res_cnt_reg, res_cnt_next;
    oaht_pkg::res_status_t m_status_reg;
    logic [oaht_pkg::IDX_W-1:0] m_slot_reg;
    logic [oaht_pkg::CNT_W-1:0] m_cnt_reg;

    // Slot memory: {state, key}
    logic [MW-1:0] mem [SLOTS];
    logic [MW-1:0] rd_data_reg;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [MW-1:0] wr_data;

    // Key reduction and probe helpers
    logic [PW-1:0]         quo;
    logic [KW-1:0]         key_rem;
    logic [SW-1:0]         addr_inc;
    logic                  issue;
    oaht_pkg::slot_state_t chk_state;
    logic [KW-1:0]         chk_key;
    logic                  chk_hit;
    logic                  load_out;

    assign quo      = prod_reg >> SH;
    assign key_rem  = key_reg - quo[KW-1:0] * KW'(SLOTS);
    assign addr_inc = (addr_reg == SW'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
    assign issue    = (iss_reg != CW'(SLOTS));
    assign chk_state = rd_data_reg[MW-1:KW];
    assign chk_key   = rd_data_reg[KW-1:0];
    assign chk_hit   = chk_valid_reg && (chk_state == oaht_pkg::ST_OCCUPIED)
                       && (chk_key == key_reg);
    assign load_out  = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {6'd0, m_cnt_reg, m_slot_reg};

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        iss_next        = iss_reg;
        chk_valid_next  = 1'b0;
        req_next        = req_reg;
        key_next        = key_reg;
        prod_next       = prod_reg;
        cnt_next        = cnt_reg;
        first_next      = first_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cnt_next    = res_cnt_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = {oaht_pkg::ST_EMPTY, {KW{1'b0}}};

        case (state_reg)
            S_CLEAR: begin
                // Sweep every slot to empty
                wr_en     = 1'b1;
                addr_next = addr_inc;
                if (addr_reg == SW'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser;
                    key_next = s_tdata[KW-1:0];
                    prod_next = {{(PW-KW){1'b0}}, s_tdata[KW-1:0]}
                                * {{(PW-RCW){1'b0}}, RECIP};
                    cnt_next = '0;
                    first_next = '0;
                    if (s_tuser inside {oaht_pkg::REQ_INSERT, oaht_pkg::REQ_SEARCH,
                                        oaht_pkg::REQ_DELETE}) begin
                        state_next = S_MOD;
                    end else begin
                        res_status_next = oaht_pkg::RES_NOT_FOUND;
                        res_slot_next   = '0;
                        res_cnt_next    = '0;
                        state_next      = S_RESP;
                    end
                end
            end
            S_MOD: begin
                // Start probing at the home slot
                addr_next  = key_rem[SW-1:0];
                iss_next   = '0;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                // Issue the next slot read
                if (issue) begin
                    addr_next      = addr_inc;
                    iss_next       = iss_reg + 1'b1;
                    chk_valid_next = 1'b1;
                end
                // Check the slot read last cycle
                case (req_reg)
                    oaht_pkg::REQ_INSERT: begin
                        if (chk_valid_reg && chk_state != oaht_pkg::ST_OCCUPIED) begin
                            wr_en           = 1'b1;
                            wr_addr         = chk_addr_reg;
                            wr_data         = {oaht_pkg::ST_OCCUPIED, key_reg};
                            res_status_next = oaht_pkg::RES_DONE;
                            res_slot_next   = oaht_pkg::IDX_W'(chk_addr_reg);
                            res_cnt_next    = '0;
                            chk_valid_next  = 1'b0;
                            state_next      = S_RESP;
                        end else if (!chk_valid_reg && !issue) begin
                            res_status_next = oaht_pkg::RES_FULL;
                            res_slot_next   = '0;
                            res_cnt_next    = '0;
                            state_next      = S_RESP;
                        end
                    end
                    oaht_pkg::REQ_SEARCH: begin
                        if (chk_hit) begin
                            res_status_next = oaht_pkg::RES_DONE;
                            res_slot_next   = oaht_pkg::IDX_W'(chk_addr_reg);
                            res_cnt_next    = '0;
                            chk_valid_next  = 1'b0;
                            state_next      = S_RESP;
                        end else if ((chk_valid_reg && chk_state == oaht_pkg::ST_EMPTY)
                                     || (!chk_valid_reg && !issue)) begin
                            res_status_next = oaht_pkg::RES_NOT_FOUND;
                            res_slot_next   = '0;
                            res_cnt_next    = '0;
                            chk_valid_next  = 1'b0;
                            state_next      = S_RESP;
                        end
                    end
                    default: begin
                        // Delete: mark every match, keep count and first slot
                        if (chk_hit) begin
                            wr_en   = 1'b1;
                            wr_addr = chk_addr_reg;
                            wr_data = {oaht_pkg::ST_DELETED, chk_key};
                            if (cnt_reg == '0) begin
                                first_next = chk_addr_reg;
                            end
                            if (cnt_reg != oaht_pkg::COUNT_MAX) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end else if (!chk_valid_reg && !issue) begin
                            if (cnt_reg == '0) begin
                                res_status_next = oaht_pkg::RES_NOT_FOUND;
                                res_slot_next   = '0;
                            end else begin
                                res_status_next = oaht_pkg::RES_DONE;
                                res_slot_next   = oaht_pkg::IDX_W'(first_reg);
                            end
                            res_cnt_next = cnt_reg;
                            state_next   = S_RESP;
                        end
                    end
                endcase
            end
            S_RESP: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            iss_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            iss_reg       <= iss_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        key_reg        <= key_next;
        prod_reg       <= prod_next;
        cnt_reg        <= cnt_next;
        first_reg      <= first_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cnt_reg    <= res_cnt_next;
        if (issue) begin
            chk_addr_reg <= addr_reg;
        end
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_cnt_reg    <= res_cnt_reg;
        end
    end

    // Slot memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
    end

endmodule

`default_nettype wire

// File: hdl/oaht_checker.sv
// ----------------------------------------------------------------------------
// oaht_checker
// Port-level checks for the open-addressing hash table, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic [31:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Drop ready for the request taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after an accepted item");

    // A failed request reports no slot and no removals
    a_fail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != oaht_pkg::RES_DONE) |->
            (m_tdata[9:0] == 10'd0) && ((m_tuser == oaht_pkg::RES_NOT_FOUND)
                                        || (m_tuser == oaht_pkg::RES_FULL)))
        else $error("failed result carries slot or count");

    // Leave reset with no result pending
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("handshake active right after reset");

endmodule

bind open_address_hash_table oaht_checker u_oaht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
